### rtl/bmsi_pkg.sv
// ----------------------------------------------------------------------------
// bmsi_pkg
// Shared types and constants for the bank mapper with scanline interrupt.
// ----------------------------------------------------------------------------
package bmsi_pkg;

    localparam int PRG_ROM_MAX_16K_DEF = 128;

    localparam logic [7:0] PRG_SIZE_RESET = 8'd32;

    localparam logic CFG_PRG_SIZE    = 1'b0;
    localparam logic CFG_FOUR_SCREEN = 1'b1;

    typedef enum logic [1:0] {
        OP_CPU_WRITE = 2'd0,
        OP_CPU_READ  = 2'd1,
        OP_PPU       = 2'd2,
        OP_NONE      = 2'd3
    } t_opcode;

    // address bits 14:13 and bit 0 of a CPU write at or above $8000
    typedef enum logic [2:0] {
        WR_BANK_SELECT = 3'b000,
        WR_BANK_DATA   = 3'b001,
        WR_MIRROR      = 3'b010,
        WR_WRAM_CTRL   = 3'b011,
        WR_IRQ_LATCH   = 3'b100,
        WR_IRQ_RELOAD  = 3'b101,
        WR_IRQ_DISABLE = 3'b110,
        WR_IRQ_ENABLE  = 3'b111
    } t_wr_reg;

    localparam logic [2:0] SEL_R6 = 3'd6;
    localparam logic [2:0] SEL_R7 = 3'd7;

    typedef struct packed {
        logic       latch_wr;
        logic       reload;
        logic       disable_irq;
        logic       enable_irq;
        logic       ppu_access;
        logic       a12;
        logic [7:0] data;
    } t_irq_cmd;

endpackage

### rtl/bmsi_irq.sv
// ----------------------------------------------------------------------------
// bmsi_irq
// Scanline counter: latch, reload request, enable, line and A12 edge detect.
// ----------------------------------------------------------------------------
module bmsi_irq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  bmsi_pkg::t_irq_cmd  i_cmd,
    output logic                o_irq_line
);

    logic [7:0] r_counter, n_counter;
    logic [7:0] r_latch, n_latch;
    logic       r_enable, n_enable;
    logic       r_reload, n_reload;
    logic       r_line, n_line;
    logic       r_prev_a12, n_prev_a12;
    logic [7:0] dec;

    assign dec = r_counter - 8'd1;

    always_comb begin
        n_counter  = r_counter;
        n_latch    = r_latch;
        n_enable   = r_enable;
        n_reload   = r_reload;
        n_line     = r_line;
        n_prev_a12 = r_prev_a12;
        if (i_cmd.latch_wr) begin
            n_latch = i_cmd.data;
        end
        if (i_cmd.reload) begin
            n_reload = 1'b1;
        end
        if (i_cmd.disable_irq) begin
            n_enable = 1'b0;
            n_line   = 1'b0;
        end
        if (i_cmd.enable_irq) begin
            n_enable = 1'b1;
        end
        if (i_cmd.ppu_access) begin
            n_prev_a12 = i_cmd.a12;
            if (!r_prev_a12 && i_cmd.a12) begin
                if (r_reload || r_counter == 8'd0) begin
                    n_counter = r_latch;
                    n_reload  = 1'b0;
                end else begin
                    n_counter = dec;
                    if (dec == 8'd0 && r_enable) begin
                        n_line = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter  <= 8'd0;
            r_latch    <= 8'd0;
            r_enable   <= 1'b0;
            r_reload   <= 1'b0;
            r_line     <= 1'b0;
            r_prev_a12 <= 1'b0;
        end else if (i_accept) begin
            r_counter  <= n_counter;
            r_latch    <= n_latch;
            r_enable   <= n_enable;
            r_reload   <= n_reload;
            r_line     <= n_line;
            r_prev_a12 <= n_prev_a12;
        end
    end

    assign o_irq_line = r_line;

endmodule

### rtl/bank_mapper_with_scanline_irq.sv
// ----------------------------------------------------------------------------
// bank_mapper_with_scanline_irq
// Cartridge bank mapper: CPU register writes, PRG and CHR bank translation,
// scanline counter clocked by rising PPU A12.
// ----------------------------------------------------------------------------
// Each beat is decoded in the cycle it is accepted and its result appears in
// the output register on the next edge; one beat per cycle is sustained while
// the output is not stalled, set by the single decode and update step between
// the input and the result register. The status outputs show the mapper state after the last beat.
// Configuration writes are taken at once (ready is always high).
module bank_mapper_with_scanline_irq #(
    parameter int PRG_ROM_MAX_16K = bmsi_pkg::PRG_ROM_MAX_16K_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_cpu_addr,
    input  logic [7:0]  i_write_data,
    input  logic [13:0] i_ppu_addr,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_prg_bank,
    output logic [7:0]  o_chr_bank,
    output logic        o_irq_line,
    output logic        o_mirror_horizontal,
    output logic        o_wram_enable,
    output logic        o_wram_protect,
    output logic [1:0]  o_wram_page,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam logic [7:0] PRG_MAX = 8'(PRG_ROM_MAX_16K);

    logic [7:0] r_prg_size;
    logic       r_four_screen;
    logic [7:0] r_bank_select;
    logic [7:0] r_chr [6];
    logic [7:0] r_r6;
    logic [7:0] r_r7;
    logic       r_mirror;
    logic [3:0] r_wram;
    logic       r_out_valid;
    logic [7:0] r_prg_out, n_prg_out;
    logic [7:0] r_chr_out, n_chr_out;

    logic               accept;
    bmsi_pkg::t_opcode  opcode;
    bmsi_pkg::t_wr_reg  wr_reg;
    logic               wr_en;
    logic [7:0]         size_c;
    logic [7:0]         last_bank;
    logic [7:0]         penult_bank;
    logic [2:0]         slot;
    bmsi_pkg::t_irq_cmd irq_cmd;

    assign o_stall     = r_out_valid && i_stall;
    assign accept      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;
    assign opcode      = bmsi_pkg::t_opcode'(i_opcode);
    assign wr_reg      = bmsi_pkg::t_wr_reg'({i_cpu_addr[14:13], i_cpu_addr[0]});
    assign wr_en       = (opcode == bmsi_pkg::OP_CPU_WRITE) && i_cpu_addr[15];

    always_comb begin
        if (r_prg_size == 8'd0) begin
            size_c = 8'd1;
        end else if (r_prg_size > PRG_MAX) begin
            size_c = PRG_MAX;
        end else begin
            size_c = r_prg_size;
        end
    end

    assign last_bank   = 8'({1'b0, size_c, 1'b0} - 10'd1);
    assign penult_bank = last_bank - 8'd1;
    assign slot        = i_ppu_addr[12:10] ^ {r_bank_select[7], 2'b00};

    always_comb begin
        n_prg_out = 8'd0;
        if (opcode == bmsi_pkg::OP_CPU_READ) begin
            case (i_cpu_addr[15:13])
                3'd4: n_prg_out = r_bank_select[6] ? penult_bank : r_r6;
                3'd5: n_prg_out = r_r7;
                3'd6: n_prg_out = r_bank_select[6] ? r_r6 : penult_bank;
                3'd7: n_prg_out = last_bank;
                default: n_prg_out = 8'd0;
            endcase
        end
    end

    always_comb begin
        n_chr_out = 8'd0;
        if (opcode == bmsi_pkg::OP_PPU && !i_ppu_addr[13]) begin
            case (slot)
                3'd0: n_chr_out = r_chr[0];
                3'd1: n_chr_out = {r_chr[0][7:1], 1'b1};
                3'd2: n_chr_out = r_chr[1];
                3'd3: n_chr_out = {r_chr[1][7:1], 1'b1};
                3'd4: n_chr_out = r_chr[2];
                3'd5: n_chr_out = r_chr[3];
                3'd6: n_chr_out = r_chr[4];
                3'd7: n_chr_out = r_chr[5];
                default: n_chr_out = 8'd0;
            endcase
        end
    end

    always_comb begin
        irq_cmd             = '0;
        irq_cmd.data        = i_write_data;
        irq_cmd.a12         = i_ppu_addr[12];
        irq_cmd.ppu_access  = (opcode == bmsi_pkg::OP_PPU);
        irq_cmd.latch_wr    = wr_en && (wr_reg == bmsi_pkg::WR_IRQ_LATCH);
        irq_cmd.reload      = wr_en && (wr_reg == bmsi_pkg::WR_IRQ_RELOAD);
        irq_cmd.disable_irq = wr_en && (wr_reg == bmsi_pkg::WR_IRQ_DISABLE);
        irq_cmd.enable_irq  = wr_en && (wr_reg == bmsi_pkg::WR_IRQ_ENABLE);
    end

    bmsi_irq u_irq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_cmd      (irq_cmd),
        .o_irq_line (o_irq_line)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_size    <= bmsi_pkg::PRG_SIZE_RESET;
            r_four_screen <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bmsi_pkg::CFG_PRG_SIZE:    r_prg_size    <= i_cfg_data;
                bmsi_pkg::CFG_FOUR_SCREEN: r_four_screen <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_select <= 8'd0;
            r_chr         <= '{default: 8'd0};
            r_r6          <= 8'd0;
            r_r7          <= 8'd0;
            r_mirror      <= 1'b0;
            r_wram        <= 4'd0;
        end else if (accept && wr_en) begin
            case (wr_reg)
                bmsi_pkg::WR_BANK_SELECT: r_bank_select <= i_write_data;
                bmsi_pkg::WR_BANK_DATA: begin
                    case (r_bank_select[2:0])
                        3'd0: r_chr[0] <= {i_write_data[7:1], 1'b0};
                        3'd1: r_chr[1] <= {i_write_data[7:1], 1'b0};
                        3'd2: r_chr[2] <= i_write_data;
                        3'd3: r_chr[3] <= i_write_data;
                        3'd4: r_chr[4] <= i_write_data;
                        3'd5: r_chr[5] <= i_write_data;
                        bmsi_pkg::SEL_R6: r_r6 <= i_write_data;
                        bmsi_pkg::SEL_R7: r_r7 <= i_write_data;
                        default: ;
                    endcase
                end
                bmsi_pkg::WR_MIRROR: begin
                    if (!r_four_screen) begin
                        r_mirror <= i_write_data[0];
                    end
                end
                bmsi_pkg::WR_WRAM_CTRL: r_wram <= {i_write_data[7:6], i_write_data[1:0]};
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prg_out <= n_prg_out;
            r_chr_out <= n_chr_out;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_prg_bank          = r_prg_out;
    assign o_chr_bank          = r_chr_out;
    assign o_mirror_horizontal = r_mirror;
    assign o_wram_enable       = r_wram[3];
    assign o_wram_protect      = r_wram[2];
    assign o_wram_page         = r_wram[1:0];

endmodule
